FILE: design/rcfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg: shared types and constants of the rc receiver frame decoder
// Item kinds, result events, register indexes, field widths and the decoded
// value record.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int FRAME_IDX_W = $clog2(FRAME_BYTES);
  localparam int COUNT_W     = 5;
  localparam int STICK_W     = 11;
  localparam int WORD_W      = 16;
  localparam int KIND_W      = 2;
  localparam int EVENT_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // tdata of a result: 130 payload bits, padded to whole bytes
  localparam int OUT_BITS   = 4 * STICK_W + 4 + 3 * WORD_W + 2 + 2 * WORD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_FRAME = COUNT_W'(FRAME_BYTES);

  localparam logic [STICK_W-1:0] STICK_OFFSET = 11'd1024;
  localparam logic [WORD_W-1:0]  WHEEL_OFFSET = 16'd1024;

  localparam logic [WORD_W-1:0]  TIMEOUT_RESET = 16'd28;
  localparam logic [STICK_W-1:0] LIMIT_RESET   = 11'd660;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // result events
  localparam logic [EVENT_W-1:0] EVT_FULL    = 2'd0;
  localparam logic [EVENT_W-1:0] EVT_PARTIAL = 2'd1;
  localparam logic [EVENT_W-1:0] EVT_LOST    = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STICK_LIMIT = 2'd1;

  // switch codes on the output
  localparam logic [1:0] SW_UNKNOWN = 2'd0;
  localparam logic [1:0] SW_UP      = 2'd1;
  localparam logic [1:0] SW_MID     = 2'd2;
  localparam logic [1:0] SW_DOWN    = 2'd3;

  // raw line codes of a switch
  localparam logic [1:0] RAW_UP   = 2'd1;
  localparam logic [1:0] RAW_MID  = 2'd3;
  localparam logic [1:0] RAW_DOWN = 2'd2;

  typedef struct packed {
    logic signed [STICK_W-1:0] right_horiz;
    logic signed [STICK_W-1:0] right_vert;
    logic signed [STICK_W-1:0] left_horiz;
    logic signed [STICK_W-1:0] left_vert;
    logic [3:0]                switches;
    logic signed [WORD_W-1:0]  mouse_x;
    logic signed [WORD_W-1:0]  mouse_y;
    logic signed [WORD_W-1:0]  mouse_z;
    logic [1:0]                mouse_buttons;
    logic [WORD_W-1:0]         keys;
    logic signed [WORD_W-1:0]  wheel;
  } rc_values_t;

  function automatic logic [1:0] map_switch(logic [1:0] raw);
    logic [1:0] code;
    unique case (raw)
      RAW_UP:   code = SW_UP;
      RAW_MID:  code = SW_MID;
      RAW_DOWN: code = SW_DOWN;
      default:  code = SW_UNKNOWN;
    endcase
    return code;
  endfunction

  // raw 11-bit stick word minus the center offset
  function automatic logic signed [STICK_W-1:0] stick_of(logic [STICK_W-1:0] raw);
    return signed'(raw - STICK_OFFSET);
  endfunction

  function automatic logic [STICK_W:0] stick_mag(logic signed [STICK_W-1:0] v);
    logic signed [STICK_W:0] ext;
    ext = {v[STICK_W-1], v};
    return v[STICK_W-1] ? (STICK_W+1)'(-ext) : (STICK_W+1)'(ext);
  endfunction

  function automatic logic [OUT_DATA_W-1:0] pack_values(rc_values_t v);
    return {(OUT_DATA_W - OUT_BITS)'(0), v.wheel, v.keys, v.mouse_buttons, v.mouse_z,
            v.mouse_y, v.mouse_x, v.switches, v.left_vert, v.left_horiz, v.right_vert,
            v.right_horiz};
  endfunction

endpackage

FILE: design/rc_receiver_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_unit: 18-byte rc receiver frame decoder
// Collects received bytes, decodes a full burst at line idle and watches the
// link age on millisecond ticks.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser carries the item kind (byte, line idle, tick),
// tdata the received byte. Output stream m_axis: tuser carries the event
// (full frame, partial update, link lost), tdata the decoded values.
// Configuration: cfg_valid/cfg_ready write channel, index 0 is the link
// timeout in milliseconds, index 1 the stick magnitude limit; always ready.
// Every item is handled in the cycle of its transfer against the stored
// state, so one item is taken per cycle while s_axis_tready is high. A result
// goes into the output register, or into the skid entry while that register is
// held. Byte items, idle items without exactly 18 bytes and most ticks give no result.
// An output register plus one skid entry sit in front of m_axis: input keeps
// flowing while one result waits, and s_axis_tready drops only while both
// hold a result the sink has not taken.
// Reset clears the byte count, link age, lost flag, decoded values and both
// result slots, and loads timeout 28 and stick limit 660.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_unit
  import rcfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // rx_byte
  input  logic [KIND_W-1:0]      s_axis_tuser,   // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // right_horiz, right_vert, left_horiz, left_vert, switches, mouse_x,
  // mouse_y, mouse_z, mouse_buttons, keys, wheel, zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [EVENT_W-1:0]     m_axis_tuser,   // event_res
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [7:0]         frame_store [FRAME_BYTES];
  logic [COUNT_W-1:0] burst_count;
  logic [WORD_W-1:0]  ms_since_frame;
  logic               lost_latched;
  rc_values_t         values;
  logic [WORD_W-1:0]  timeout_ms;
  logic [STICK_W-1:0] stick_limit;

  logic [COUNT_W-1:0] burst_count_next;
  logic [WORD_W-1:0]  ms_since_frame_next;
  logic               lost_latched_next;
  rc_values_t         values_next;
  logic               produce;
  logic [EVENT_W-1:0] event_next;
  logic               store_clear;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic [EVENT_W-1:0]    out_event;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic [EVENT_W-1:0]    skid_event;

  logic               in_fire;
  logic               out_free;
  rc_values_t         frame_dec;
  logic               out_of_range;
  logic [WORD_W-1:0]  ms_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // field extraction from the stored frame
  always_comb begin
    frame_dec.right_horiz   = stick_of({frame_store[1][2:0], frame_store[0]});
    frame_dec.right_vert    = stick_of({frame_store[2][5:0], frame_store[1][7:3]});
    frame_dec.left_horiz    = stick_of({frame_store[4][0], frame_store[3],
                                        frame_store[2][7:6]});
    frame_dec.left_vert     = stick_of({frame_store[5][3:0], frame_store[4][7:1]});
    frame_dec.switches      = {map_switch(frame_store[5][7:6]),
                               map_switch(frame_store[5][5:4])};
    frame_dec.mouse_x       = signed'({frame_store[7], frame_store[6]});
    frame_dec.mouse_y       = signed'({frame_store[9], frame_store[8]});
    frame_dec.mouse_z       = signed'({frame_store[11], frame_store[10]});
    frame_dec.mouse_buttons = {frame_store[13] != 8'd0, frame_store[12] != 8'd0};
    frame_dec.keys          = {frame_store[15], frame_store[14]};
    frame_dec.wheel         = signed'({frame_store[17], frame_store[16]} - WHEEL_OFFSET);
  end

  assign out_of_range = (stick_mag(frame_dec.right_horiz) > {1'b0, stick_limit}) ||
                        (stick_mag(frame_dec.right_vert)  > {1'b0, stick_limit}) ||
                        (stick_mag(frame_dec.left_horiz)  > {1'b0, stick_limit}) ||
                        (stick_mag(frame_dec.left_vert)   > {1'b0, stick_limit});

  assign ms_inc = (ms_since_frame == '1) ? ms_since_frame : ms_since_frame + 1'b1;

  always_comb begin
    burst_count_next    = burst_count;
    ms_since_frame_next = ms_since_frame;
    lost_latched_next   = lost_latched;
    values_next         = values;
    produce             = 1'b0;
    event_next          = EVT_FULL;
    store_clear         = 1'b0;
    if (in_fire) begin
      unique case (s_axis_tuser)
        KIND_BYTE: begin
          if (burst_count != COUNT_MAX) begin
            burst_count_next = burst_count + 1'b1;
          end
        end
        KIND_IDLE: begin
          burst_count_next = '0;
          if (burst_count == COUNT_FRAME) begin
            produce                 = 1'b1;
            values_next.right_horiz = frame_dec.right_horiz;
            values_next.right_vert  = frame_dec.right_vert;
            values_next.left_horiz  = frame_dec.left_horiz;
            values_next.left_vert   = frame_dec.left_vert;
            values_next.switches    = frame_dec.switches;
            if (out_of_range) begin
              event_next = EVT_PARTIAL;
            end else begin
              event_next          = EVT_FULL;
              values_next         = frame_dec;
              ms_since_frame_next = '0;
            end
          end
        end
        KIND_TICK: begin
          ms_since_frame_next = ms_inc;
          if (ms_inc > timeout_ms) begin
            if (!lost_latched) begin
              produce           = 1'b1;
              event_next        = EVT_LOST;
              values_next       = '0;
              lost_latched_next = 1'b1;
              store_clear       = 1'b1;
            end
          end else begin
            lost_latched_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // byte store, written by byte transfers within the frame length,
  // wiped when the link is declared lost
  always_ff @(posedge clk) begin
    if (store_clear) begin
      frame_store <= '{default: 8'd0};
    end else if (in_fire && s_axis_tuser == KIND_BYTE && burst_count < COUNT_FRAME) begin
      frame_store[burst_count[FRAME_IDX_W-1:0]] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count    <= '0;
      ms_since_frame <= '0;
      lost_latched   <= 1'b0;
      values         <= '0;
    end else begin
      burst_count    <= burst_count_next;
      ms_since_frame <= ms_since_frame_next;
      lost_latched   <= lost_latched_next;
      values         <= values_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms  <= TIMEOUT_RESET;
      stick_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT:     timeout_ms  <= cfg_data;
        CFG_STICK_LIMIT: stick_limit <= cfg_data[STICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register with one skid entry
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        out_event <= skid_event;
      end else if (produce) begin
        out_data  <= pack_values(values_next);
        out_event <= event_next;
      end
    end else if (produce) begin
      skid_data  <= pack_values(values_next);
      skid_event <= event_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_event;

endmodule

FILE: test/rcfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_checker: result predictor and scoreboard for the rc frame decoder
// Watches the config, input and output channels. Keeps its own copy of the
// byte store, link age and decoded values, queues one expected result per
// decoded burst or link loss, and compares every output transfer field by
// field against the oldest entry.
// ----------------------------------------------------------------------------
module rcfd_checker
  import rcfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic [KIND_W-1:0]      s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic [EVENT_W-1:0]     m_axis_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     n_items,
  output int                     n_full,
  output int                     n_partial,
  output int                     n_lost
);

  typedef struct packed {
    logic [EVENT_W-1:0] evt;
    rc_values_t         vals;
  } rc_result_t;

  rc_result_t         decoded_q[$];
  logic [7:0]         frame_mem [FRAME_BYTES];
  logic [COUNT_W-1:0] byte_cnt;
  logic [WORD_W-1:0]  link_age;
  logic               lost_flag;
  rc_values_t         shown;
  logic [WORD_W-1:0]  timeout_reg;
  logic [STICK_W-1:0] limit_reg;

  int err_cnt  = 0;
  int item_cnt = 0;
  int full_cnt = 0;
  int part_cnt = 0;
  int lost_cnt = 0;

  function automatic logic [1:0] switch_code(logic [1:0] raw);
    case (raw)
      RAW_UP:   return SW_UP;
      RAW_MID:  return SW_MID;
      RAW_DOWN: return SW_DOWN;
      default:  return SW_UNKNOWN;
    endcase
  endfunction

  function automatic int stick_abs(logic [STICK_W-1:0] raw);
    int v;
    v = int'(raw) - int'(STICK_OFFSET);
    return (v < 0) ? -v : v;
  endfunction

  // field order of tdata, lowest bits first
  function automatic rc_values_t split_tdata(logic [OUT_DATA_W-1:0] d);
    rc_values_t v;
    v.right_horiz   = d[10:0];
    v.right_vert    = d[21:11];
    v.left_horiz    = d[32:22];
    v.left_vert     = d[43:33];
    v.switches      = d[47:44];
    v.mouse_x       = d[63:48];
    v.mouse_y       = d[79:64];
    v.mouse_z       = d[95:80];
    v.mouse_buttons = d[97:96];
    v.keys          = d[113:98];
    v.wheel         = d[129:114];
    return v;
  endfunction

  task automatic queue_result(logic [EVENT_W-1:0] evt);
    rc_result_t r;
    r.evt  = evt;
    r.vals = shown;
    decoded_q.push_back(r);
  endtask

  task automatic decode_burst();
    logic [STICK_W-1:0] raw [4];
    bit over;
    raw[0] = {frame_mem[1][2:0], frame_mem[0]};
    raw[1] = {frame_mem[2][5:0], frame_mem[1][7:3]};
    raw[2] = {frame_mem[4][0], frame_mem[3], frame_mem[2][7:6]};
    raw[3] = {frame_mem[5][3:0], frame_mem[4][7:1]};
    shown.right_horiz = raw[0] - STICK_OFFSET;
    shown.right_vert  = raw[1] - STICK_OFFSET;
    shown.left_horiz  = raw[2] - STICK_OFFSET;
    shown.left_vert   = raw[3] - STICK_OFFSET;
    shown.switches    = {switch_code(frame_mem[5][7:6]), switch_code(frame_mem[5][5:4])};
    over = 1'b0;
    foreach (raw[k]) begin
      if (stick_abs(raw[k]) > int'(limit_reg)) over = 1'b1;
    end
    // out of range sticks: everything past the switches keeps its old value
    if (over) begin
      queue_result(EVT_PARTIAL);
    end else begin
      shown.mouse_x       = {frame_mem[7], frame_mem[6]};
      shown.mouse_y       = {frame_mem[9], frame_mem[8]};
      shown.mouse_z       = {frame_mem[11], frame_mem[10]};
      shown.mouse_buttons = {frame_mem[13] != 8'd0, frame_mem[12] != 8'd0};
      shown.keys          = {frame_mem[15], frame_mem[14]};
      shown.wheel         = {frame_mem[17], frame_mem[16]} - WHEEL_OFFSET;
      link_age = '0;
      queue_result(EVT_FULL);
    end
  endtask

  task automatic take_item(logic [KIND_W-1:0] kind, logic [7:0] data);
    bit complete;
    case (kind)
      KIND_BYTE: begin
        if (byte_cnt < COUNT_FRAME) frame_mem[byte_cnt] = data;
        if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 1'b1;
      end
      KIND_IDLE: begin
        complete = (byte_cnt == COUNT_FRAME);
        byte_cnt = '0;
        if (complete) decode_burst();
      end
      KIND_TICK: begin
        if (link_age != '1) link_age = link_age + 1'b1;
        if (link_age > timeout_reg) begin
          if (!lost_flag) begin
            shown = '0;
            foreach (frame_mem[i]) frame_mem[i] = 8'd0;
            lost_flag = 1'b1;
            queue_result(EVT_LOST);
          end
        end else begin
          lost_flag = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
    if (want !== seen) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
    end
  endtask

  task automatic check_result();
    rc_result_t want;
    rc_values_t seen;
    if (decoded_q.size() == 0) begin
      err_cnt++;
      $display("%0t: result with none expected, expected nothing, actual event %0d data %h",
               $time, m_axis_tuser, m_axis_tdata);
    end else begin
      want = decoded_q.pop_front();
      seen = split_tdata(m_axis_tdata);
      case (want.evt)
        EVT_FULL:    full_cnt++;
        EVT_PARTIAL: part_cnt++;
        default:     lost_cnt++;
      endcase
      check_field("event_res", WORD_W'(want.evt), WORD_W'(m_axis_tuser));
      check_field("right_horiz", WORD_W'(want.vals.right_horiz),
                  WORD_W'(seen.right_horiz));
      check_field("right_vert", WORD_W'(want.vals.right_vert), WORD_W'(seen.right_vert));
      check_field("left_horiz", WORD_W'(want.vals.left_horiz), WORD_W'(seen.left_horiz));
      check_field("left_vert", WORD_W'(want.vals.left_vert), WORD_W'(seen.left_vert));
      check_field("switches", WORD_W'(want.vals.switches), WORD_W'(seen.switches));
      check_field("mouse_x", want.vals.mouse_x, seen.mouse_x);
      check_field("mouse_y", want.vals.mouse_y, seen.mouse_y);
      check_field("mouse_z", want.vals.mouse_z, seen.mouse_z);
      check_field("mouse_buttons", WORD_W'(want.vals.mouse_buttons),
                  WORD_W'(seen.mouse_buttons));
      check_field("keys", want.vals.keys, seen.keys);
      check_field("wheel", want.vals.wheel, seen.wheel);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decoded_q.delete();
      foreach (frame_mem[i]) frame_mem[i] = 8'd0;
      byte_cnt    = '0;
      link_age    = '0;
      lost_flag   = 1'b0;
      shown       = '0;
      timeout_reg = TIMEOUT_RESET;
      limit_reg   = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT:     timeout_reg = cfg_data;
          CFG_STICK_LIMIT: limit_reg = cfg_data[STICK_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item_cnt++;
        take_item(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    errors    <= err_cnt;
    pending   <= decoded_q.size();
    n_items   <= item_cnt;
    n_full    <= full_cnt;
    n_partial <= part_cnt;
    n_lost    <= lost_cnt;
  end

endmodule

FILE: test/tb_rc_receiver_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_receiver_frame_decoder_unit: stimulus and verdict for the decoder
// Drives byte, line idle and tick items with random gaps and a randomly
// stalling sink, walks through a series of timeout and stick limit settings,
// and leaves all prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_rc_receiver_frame_decoder_unit;
  import rcfd_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1050;

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;
  logic [KIND_W-1:0]      s_axis_tuser  = KIND_BYTE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [EVENT_W-1:0]     m_axis_tuser;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index     = CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  int errors, pending, n_items, n_full, n_partial, n_lost;

  bit         calm       = 1'b0;
  int         n_sent     = 0;
  int         n_writes   = 0;
  int         n_settings = 0;
  int         cur_tmo    = 28;
  int         cur_lim    = 660;
  logic [7:0] fb [FRAME_BYTES];

  rc_receiver_frame_decoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rcfd_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .n_items       (n_items),
    .n_full        (n_full),
    .n_partial     (n_partial),
    .n_lost        (n_lost)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout: stimulus or results stuck, %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // stick raw word, mostly inside the current magnitude limit
  function automatic logic [STICK_W-1:0] pick_raw(int lim);
    int lo, hi;
    if ($urandom_range(0, 3) == 0) return STICK_W'($urandom_range(0, 2047));
    lo = 1024 - lim;
    hi = (1024 + lim > 2047) ? 2047 : 1024 + lim;
    return STICK_W'($urandom_range(hi, lo));
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] data);
    int gap;
    gap = pick_wait();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind != KIND_SPARE) n_sent++;
  endtask

  task automatic send_frame();
    foreach (fb[i]) send_item(KIND_BYTE, fb[i]);
    send_item(KIND_IDLE, 8'($urandom_range(0, 255)));
  endtask

  // n bytes, unused-kind items sprinkled in, then line idle
  task automatic send_burst(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(KIND_SPARE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
    send_item(KIND_IDLE, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic fill_frame(input logic [STICK_W-1:0] r0, r1, r2, r3,
                            input logic [1:0] sw_left, sw_right);
    foreach (fb[i]) fb[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) fb[12] = 8'd0;
    if ($urandom_range(0, 2) == 0) fb[13] = 8'd0;
    fb[0] = r0[7:0];
    fb[1] = {r1[4:0], r0[10:8]};
    fb[2] = {r2[1:0], r1[10:5]};
    fb[3] = r2[9:2];
    fb[4] = {r3[6:0], r2[10]};
    fb[5] = {sw_left, sw_right, r3[10:7]};
  endtask

  task automatic random_frame();
    fill_frame(pick_raw(cur_lim), pick_raw(cur_lim), pick_raw(cur_lim), pick_raw(cur_lim),
               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    send_frame();
  endtask

  // drop valid, drain every expected result, then a short settle pause
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input int tmo, input int lim);
    cur_tmo = tmo;
    cur_lim = lim;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= CFG_DATA_W'(tmo);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_STICK_LIMIT;
    cfg_data  <= CFG_DATA_W'(lim);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_writes += 2;
    n_settings++;
  endtask

  // sink side, one stall draw per result
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin
    int tmo, lim, pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // extremes of the byte values and of the stick range
    set_regs(28, 1024);
    foreach (fb[i]) fb[i] = 8'h00;
    send_frame();
    foreach (fb[i]) fb[i] = 8'hFF;
    send_frame();
    fill_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, RAW_UP, RAW_DOWN);
    send_frame();

    wait_quiet();
    set_regs(28, 0);
    fill_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, RAW_MID, 2'b00);
    send_frame();
    fill_frame(11'd1024, 11'd1025, 11'd1024, 11'd1024, RAW_DOWN, RAW_UP);
    send_frame();

    // magnitudes right at the limit and one past it
    wait_quiet();
    set_regs(28, 660);
    fill_frame(11'd1684, 11'd364, 11'd1024, 11'd1024, RAW_UP, RAW_MID);
    send_frame();
    fill_frame(11'd1024, 11'd1024, 11'd363, 11'd1024, RAW_MID, RAW_DOWN);
    send_frame();
    fill_frame(11'd1024, 11'd1024, 11'd1024, 11'd1685, 2'b00, RAW_UP);
    send_frame();

    // short, long and saturating bursts, a bare idle and an unused kind
    send_burst(17);
    send_burst(19);
    send_burst(40);
    send_burst(0);
    send_item(KIND_SPARE, 8'hA5);
    fill_frame(11'd1000, 11'd1100, 11'd900, 11'd1200, RAW_UP, RAW_MID);
    send_frame();

    // zero timeout: lost after any tick, and it stays latched
    wait_quiet();
    set_regs(0, 660);
    send_ticks(2);
    fill_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, RAW_UP, RAW_UP);
    send_frame();
    send_ticks(1);

    // latch clears while young, partial update leaves the age running
    wait_quiet();
    set_regs(3, 660);
    fill_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, RAW_DOWN, RAW_DOWN);
    send_frame();
    send_ticks(5);
    fill_frame(11'd0, 11'd1024, 11'd1024, 11'd1024, RAW_UP, RAW_DOWN);
    send_frame();
    send_ticks(1);
    fill_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, RAW_MID, RAW_MID);
    send_frame();
    send_ticks(4);

    while (n_sent < ITEM_TARGET) begin
      wait_quiet();
      pick = $urandom_range(0, 5);
      case (pick)
        0:       tmo = 1;
        1:       tmo = 65535;
        2:       tmo = $urandom_range(1, 65535);
        default: tmo = $urandom_range(2, 40);
      endcase
      pick = $urandom_range(0, 5);
      case (pick)
        0:       lim = 0;
        1:       lim = 1024;
        default: lim = $urandom_range(0, 1024);
      endcase
      set_regs(tmo, lim);
      calm = ($urandom_range(0, 3) == 0);
      repeat (6) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          random_frame();
          send_ticks($urandom_range(0, 3));
        end else if (pick == 7) begin
          if (cur_tmo < 60) send_ticks(cur_tmo + $urandom_range(1, 4));
          else send_ticks($urandom_range(1, 6));
        end else begin
          send_burst($urandom_range(0, 35));
        end
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    $display("covered %0d input transfers and %0d register writes over %0d settings",
             n_items, n_writes, n_settings);
    $display("checked %0d full frames, %0d partial updates, %0d link losses",
             n_full, n_partial, n_lost);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
